// File: hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
	else $error("assertion failed");

// Antecedent in this cycle, consequent in the next one.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");

`endif

// File: hw/rtl/rmq_pkg.sv
package rmq_pkg;

	localparam int QW     = 18;   // Q2.16 field width
	localparam int DW     = 19;   // sum or difference of two fields
	localparam int VW     = 20;   // candidate value, unsigned
	localparam int RADW   = 50;   // value shifted up by 30
	localparam int ROOTW  = 25;   // floor(sqrt) width
	localparam int SREMW  = 27;
	localparam int SQ_CELLS = 25;
	localparam int QUOW   = 20;   // quotient bits
	localparam int DREMW  = 26;
	localparam int DIV_CELLS = 20;
	localparam int LANES  = 3;

	localparam logic [VW-1:0] THRESH = VW'(4096);

	typedef enum logic [1:0] {
		CAND_W = 2'd0,
		CAND_Z = 2'd1,
		CAND_Y = 2'd2,
		CAND_X = 2'd3
	} cand_t;

	typedef struct packed {
		logic                 ok;
		cand_t                k;
		logic signed [DW-1:0] d0;
		logic signed [DW-1:0] d1;
		logic signed [DW-1:0] d2;
	} sq_side_t;

	typedef struct packed {
		logic [SREMW-1:0] rem;
		logic [ROOTW-1:0] root;
		logic [RADW-1:0]  rad;
	} sq_word_t;

	typedef struct packed {
		logic             ok;
		cand_t            k;
		logic [QW-1:0]    mainc;
		logic [LANES-1:0] neg;
		logic [ROOTW-1:0] q;
	} dv_side_t;

	typedef struct packed {
		logic [DREMW-1:0] rem;
		logic [QUOW-1:0]  num;
		logic [QUOW-1:0]  quo;
	} dv_lane_t;

endpackage

// File: hw/rtl/rmq_sqrt_cell.sv
module rmq_sqrt_cell import rmq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     in_v,
	input  sq_side_t in_side,
	input  sq_word_t in_word,
	output logic     out_v,
	output sq_side_t out_side,
	output sq_word_t out_word
);

	logic [SREMW-1:0] cur;
	logic [SREMW-1:0] trial;
	sq_word_t         nxt;

	always_comb begin
		cur   = {in_word.rem[SREMW-3:0], in_word.rad[RADW-1 -: 2]};
		trial = {in_word.root, 2'b01};
		nxt.rad = {in_word.rad[RADW-3:0], 2'b00};
		if (cur >= trial) begin
			nxt.rem  = cur - trial;
			nxt.root = {in_word.root[ROOTW-2:0], 1'b1};
		end else begin
			nxt.rem  = cur;
			nxt.root = {in_word.root[ROOTW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (en) begin
			out_v <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_side <= in_side;
			out_word <= nxt;
		end
	end

endmodule

// File: hw/rtl/rmq_div_cell.sv
module rmq_div_cell import rmq_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_v,
	input  dv_side_t            in_side,
	input  dv_lane_t [LANES-1:0] in_lane,
	output logic                out_v,
	output dv_side_t            out_side,
	output dv_lane_t [LANES-1:0] out_lane
);

	dv_lane_t [LANES-1:0] nxt;
	logic [DREMW-1:0]     part [LANES];

	always_comb begin
		for (int j = 0; j < LANES; j++) begin
			part[j] = {in_lane[j].rem[DREMW-2:0], in_lane[j].num[QUOW-1]};
			nxt[j].num = {in_lane[j].num[QUOW-2:0], 1'b0};
			if (part[j] >= {1'b0, in_side.q}) begin
				nxt[j].rem = part[j] - {1'b0, in_side.q};
				nxt[j].quo = {in_lane[j].quo[QUOW-2:0], 1'b1};
			end else begin
				nxt[j].rem = part[j];
				nxt[j].quo = {in_lane[j].quo[QUOW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (en) begin
			out_v <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_side <= in_side;
			out_lane <= nxt;
		end
	end

endmodule

// File: hw/rtl/rotation_matrix_to_quaternion_core.sv
// Channel   Direction  tdata                          tuser
// s_*       in         m11..m33, 18 bits each (168)   -
// m_*       out        quat_x..quat_w, 18 each (72)   valid_res
//
// Stages: input stage, 25 square-root cells, numerator stage, 20 divider
// cells, output stage. One matrix per cycle while the skid register is empty.
// The square root resolves one root bit per cell, the three quotients one
// bit per divider cell. Reset clears only valid flags.
// A downstream stall first fills a one-entry skid register; s_tready drops
// only while it is full, and the whole chain holds.
module rotation_matrix_to_quaternion_core import rmq_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [167:0] s_tdata,   // m11, m12, m13, m21, m22, m23, m31, m32, m33, pad
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [71:0]  m_tdata,   // quat_x, quat_y, quat_z, quat_w
	output logic         m_tuser    // valid_res
);

	logic en;
	logic skid_v_q;

	assign en       = !skid_v_q;
	assign s_tready = !skid_v_q;

	// input stage: pick candidate
	logic signed [QW-1:0] m [9];
	logic signed [VW:0]   v [4];
	logic signed [VW:0]   one;
	sq_side_t             side0;
	logic [VW-1:0]        vsel;

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			m[i] = s_tdata[i*QW +: QW];
		end
		one  = (VW+1)'(65536);
		v[0] = (VW+1)'(m[0]) + (VW+1)'(m[4]) + (VW+1)'(m[8]) + one;
		v[1] = -(VW+1)'(m[0]) - (VW+1)'(m[4]) + (VW+1)'(m[8]) + one;
		v[2] = -(VW+1)'(m[0]) + (VW+1)'(m[4]) - (VW+1)'(m[8]) + one;
		v[3] = (VW+1)'(m[0]) - (VW+1)'(m[4]) - (VW+1)'(m[8]) + one;
		side0.ok = 1'b1;
		vsel     = '0;
		if (v[0] > $signed({1'b0, THRESH})) begin
			side0.k  = CAND_W;
			vsel     = v[0][VW-1:0];
			side0.d0 = DW'(m[7]) - DW'(m[5]);
			side0.d1 = DW'(m[2]) - DW'(m[6]);
			side0.d2 = DW'(m[3]) - DW'(m[1]);
		end else if (v[1] > $signed({1'b0, THRESH})) begin
			side0.k  = CAND_Z;
			vsel     = v[1][VW-1:0];
			side0.d0 = DW'(m[2]) + DW'(m[6]);
			side0.d1 = DW'(m[5]) + DW'(m[7]);
			side0.d2 = DW'(m[3]) - DW'(m[1]);
		end else if (v[2] > $signed({1'b0, THRESH})) begin
			side0.k  = CAND_Y;
			vsel     = v[2][VW-1:0];
			side0.d0 = DW'(m[1]) + DW'(m[3]);
			side0.d1 = DW'(m[5]) + DW'(m[7]);
			side0.d2 = DW'(m[2]) - DW'(m[6]);
		end else begin
			side0.k  = CAND_X;
			vsel     = v[3][VW-1:0];
			side0.d0 = DW'(m[1]) + DW'(m[3]);
			side0.d1 = DW'(m[2]) + DW'(m[6]);
			side0.d2 = DW'(m[7]) - DW'(m[5]);
			if (!(v[3] > $signed({1'b0, THRESH}))) begin
				side0.ok = 1'b0;
				vsel     = '0;
			end
		end
	end

	logic     sq_v    [SQ_CELLS+1];
	sq_side_t sq_side [SQ_CELLS+1];
	sq_word_t sq_word [SQ_CELLS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v[0] <= 1'b0;
		end else if (en) begin
			sq_v[0] <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_side[0]      <= side0;
			sq_word[0].rem  <= '0;
			sq_word[0].root <= '0;
			sq_word[0].rad  <= {vsel, 30'b0};
		end
	end

	for (genvar i = 0; i < SQ_CELLS; i++) begin : g_sq
		rmq_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_v     (sq_v[i]),
			.in_side  (sq_side[i]),
			.in_word  (sq_word[i]),
			.out_v    (sq_v[i+1]),
			.out_side (sq_side[i+1]),
			.out_word (sq_word[i+1])
		);
	end

	// numerator stage: |D| * 2^22 + q/2
	sq_side_t             sl;
	logic [ROOTW-1:0]     qr;
	logic signed [DW-1:0] dsel [LANES];
	logic [DW-1:0]        mag  [LANES];
	logic [41:0]          numr [LANES];
	dv_side_t             dside0;
	dv_lane_t [LANES-1:0] dlane0;
	logic [ROOTW-1:0]     rnd;

	always_comb begin
		sl  = sq_side[SQ_CELLS];
		qr  = sq_word[SQ_CELLS].root;
		rnd = qr + ROOTW'(128);
		dsel[0] = sl.d0;
		dsel[1] = sl.d1;
		dsel[2] = sl.d2;
		dside0.ok    = sl.ok;
		dside0.k     = sl.k;
		dside0.q     = qr;
		dside0.mainc = QW'(rnd[ROOTW-1:8]);
		for (int j = 0; j < LANES; j++) begin
			dside0.neg[j] = dsel[j][DW-1];
			mag[j]  = dsel[j][DW-1] ? DW'(-dsel[j]) : DW'(dsel[j]);
			numr[j] = {1'b0, mag[j], 22'b0} + 42'(qr[ROOTW-1:1]);
			dlane0[j].rem = DREMW'(numr[j][41:QUOW]);
			dlane0[j].num = numr[j][QUOW-1:0];
			dlane0[j].quo = '0;
		end
	end

	logic                 dv_v    [DIV_CELLS+1];
	dv_side_t             dv_side [DIV_CELLS+1];
	dv_lane_t [LANES-1:0] dv_lane [DIV_CELLS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v[0] <= 1'b0;
		end else if (en) begin
			dv_v[0] <= sq_v[SQ_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_side[0] <= dside0;
			dv_lane[0] <= dlane0;
		end
	end

	for (genvar i = 0; i < DIV_CELLS; i++) begin : g_dv
		rmq_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_v     (dv_v[i]),
			.in_side  (dv_side[i]),
			.in_lane  (dv_lane[i]),
			.out_v    (dv_v[i+1]),
			.out_side (dv_side[i+1]),
			.out_lane (dv_lane[i+1])
		);
	end

	// output stage: sign, saturate, place components
	dv_side_t      fs;
	logic [QW-1:0] r [LANES];
	logic [QUOW-1:0] qu;
	logic [71:0]   res;

	always_comb begin
		fs = dv_side[DIV_CELLS];
		for (int j = 0; j < LANES; j++) begin
			qu = dv_lane[DIV_CELLS][j].quo;
			if (fs.neg[j]) begin
				r[j] = (qu > QUOW'(131072)) ? QW'(-131072) : QW'(-qu);
			end else begin
				r[j] = (qu > QUOW'(131071)) ? QW'(131071) : QW'(qu);
			end
		end
		case (fs.k)
			CAND_W:  res = {fs.mainc, r[2], r[1], r[0]};
			CAND_Z:  res = {r[2], fs.mainc, r[1], r[0]};
			CAND_Y:  res = {r[2], r[1], fs.mainc, r[0]};
			CAND_X:  res = {r[2], r[1], r[0], fs.mainc};
			default: res = '0;
		endcase
		if (!fs.ok) begin
			res = '0;
		end
	end

	logic        out_v_s48;
	logic [71:0] out_d_s48;
	logic        out_u_s48;
	logic [71:0] skid_d_q;
	logic        skid_u_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_s48 <= 1'b0;
			skid_v_q  <= 1'b0;
		end else begin
			if (en) begin
				out_v_s48 <= dv_v[DIV_CELLS];
			end
			// park the held result when the sink stalls
			if (skid_v_q) begin
				if (m_tready) begin
					skid_v_q <= 1'b0;
				end
			end else if (out_v_s48 && !m_tready) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_d_s48 <= res;
			out_u_s48 <= fs.ok;
		end
		if (!skid_v_q) begin
			skid_d_q <= out_d_s48;
			skid_u_q <= out_u_s48;
		end
	end

	assign m_tvalid = skid_v_q | out_v_s48;
	assign m_tdata  = skid_v_q ? skid_d_q : out_d_s48;
	assign m_tuser  = skid_v_q ? skid_u_q : out_u_s48;

endmodule

// File: hw/rtl/rmq_checker.sv
`include "assert_macros.svh"

module rmq_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [167:0] s_tdata,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [71:0]  m_tdata,
	input logic         m_tuser
);

	`ASSERT_NEXT(a_in_hold, clk, arst_n, s_tvalid && !s_tready, s_tvalid && $stable(s_tdata))
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	`ASSERT_CLK(a_invalid_zero, clk, arst_n, !(m_tvalid && !m_tuser) || (m_tdata == 72'd0))
	`ASSERT_CLK(a_ready_drop, clk, arst_n, s_tready || $past(m_tvalid && !m_tready))

endmodule

bind rotation_matrix_to_quaternion_core rmq_checker u_rmq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// File: tb/sv/rotation_matrix_to_quaternion_core_test.sv
`timescale 1ns / 100ps

module rotation_matrix_to_quaternion_core_test;
	import rmq_pkg::*;

	localparam int N_RANDOM = 700;
	localparam logic signed [17:0] P_ONE = 18'sd65536;
	localparam logic signed [17:0] S_MAX = 18'sd131071;
	localparam logic signed [17:0] S_MIN = -18'sd131072;

	typedef logic signed [17:0] q16_t;
	typedef q16_t mat_t [9];

	typedef struct {
		q16_t x, y, z, w;
		logic ok;
	} quat_t;

	typedef struct {
		mat_t m;
		logic known;
		quat_t q;
	} vector_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [167:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [71:0] m_tdata;
	logic m_tuser;

	quat_t quat_queue[$];
	vector_t vectors[$];
	int errors;
	bit sending;
	bit hold_off;

	rotation_matrix_to_quaternion_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("Some tests failed");
		$finish;
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic q16_t clamp18(longint v);
		if (v > S_MAX) return S_MAX;
		if (v < S_MIN) return S_MIN;
		return q16_t'(v);
	endfunction

	// D/(4c), rounded half away from zero
	function automatic q16_t scaled_div(longint d, longint unsigned root);
		longint n;
		longint unsigned mag, r;
		n = d * (64'sd1 <<< 22);
		mag = (n < 0) ? longint'(-n) : n;
		r = (mag + root / 2) / root;
		if (r > (64'd1 << 40)) r = 64'd1 << 40;
		return clamp18((n < 0) ? -longint'(r) : longint'(r));
	endfunction

	function automatic quat_t matrix_to_quat(mat_t m);
		quat_t r;
		longint a [9];
		longint cand [4];
		longint unsigned root;
		q16_t mainc;
		r = '{0, 0, 0, 0, 1'b0};
		foreach (a[i]) a[i] = m[i];
		cand[CAND_W] = a[0] + a[4] + a[8] + 65536;
		cand[CAND_Z] = -a[0] - a[4] + a[8] + 65536;
		cand[CAND_Y] = -a[0] + a[4] - a[8] + 65536;
		cand[CAND_X] = a[0] - a[4] - a[8] + 65536;
		for (int k = 0; k < 4; k++) begin
			if (cand[k] > 4096) begin
				root = int_sqrt(longint'(cand[k]) << 30);
				mainc = clamp18((root + 128) >> 8);
				r.ok = 1;
				case (cand_t'(k))
					CAND_W: begin
						r.w = mainc;
						r.x = scaled_div(a[7] - a[5], root);
						r.y = scaled_div(a[2] - a[6], root);
						r.z = scaled_div(a[3] - a[1], root);
					end
					CAND_Z: begin
						r.z = mainc;
						r.x = scaled_div(a[2] + a[6], root);
						r.y = scaled_div(a[5] + a[7], root);
						r.w = scaled_div(a[3] - a[1], root);
					end
					CAND_Y: begin
						r.y = mainc;
						r.x = scaled_div(a[1] + a[3], root);
						r.z = scaled_div(a[5] + a[7], root);
						r.w = scaled_div(a[2] - a[6], root);
					end
					default: begin
						r.x = mainc;
						r.y = scaled_div(a[1] + a[3], root);
						r.z = scaled_div(a[2] + a[6], root);
						r.w = scaled_div(a[7] - a[5], root);
					end
				endcase
				break;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		errors++;
	endtask

	function automatic mat_t diag(q16_t a, q16_t b, q16_t c);
		mat_t m;
		foreach (m[i]) m[i] = 0;
		m[0] = a;
		m[4] = b;
		m[8] = c;
		return m;
	endfunction

	function automatic mat_t fill(q16_t v);
		mat_t m;
		foreach (m[i]) m[i] = v;
		return m;
	endfunction

	function automatic mat_t random_matrix(bit rotation_like);
		mat_t m;
		foreach (m[i]) begin
			if (rotation_like) m[i] = q16_t'($urandom_range(0, 131072) - 65536);
			else m[i] = q16_t'($urandom);
		end
		return m;
	endfunction

	task automatic add_known(mat_t m, quat_t q);
		vectors.push_back('{m, 1'b1, q});
	endtask

	task automatic add_row(mat_t m);
		vectors.push_back('{m, 1'b0, '{0, 0, 0, 0, 1'b0}});
	endtask

	task automatic build_directed();
		mat_t m;
		// identity: w = 1
		add_known(diag(P_ONE, P_ONE, P_ONE), '{0, 0, 0, P_ONE, 1'b1});
		// rotations by pi about each axis pick the z, y and x candidates
		add_known(diag(-P_ONE, -P_ONE, P_ONE), '{0, 0, P_ONE, 0, 1'b1});
		add_known(diag(-P_ONE, P_ONE, -P_ONE), '{0, P_ONE, 0, 0, 1'b1});
		add_known(diag(P_ONE, -P_ONE, -P_ONE), '{P_ONE, 0, 0, 0, 1'b1});
		// zero matrix: all four candidates qualify, the trace candidate wins, w = 1/2
		add_known(fill(0) , '{0, 0, 0, P_ONE/2, 1'b1});
		vectors.pop_back();
		add_row(fill(0));
		m = fill(0);
		m[0] = P_ONE; m[4] = P_ONE; m[8] = P_ONE;
		// the four candidates always sum to 4, so one of them qualifies
		add_row(diag(S_MIN, S_MIN, S_MIN));
		add_row(fill(S_MAX));
		add_row(fill(S_MIN));
		add_row(fill(-18'sd1));
		add_row(diag(-18'sd20480, -18'sd20480, -18'sd20480));
		add_row(diag(-18'sd20479, -18'sd20479, -18'sd20479));
		m = diag(-18'sd20480, -18'sd20480, -18'sd20481);
		add_row(m);
		// tiny candidate, huge off-diagonal: saturate
		m = diag(-18'sd20479, -18'sd20479, -18'sd20479);
		m[1] = S_MIN; m[2] = S_MAX; m[3] = S_MAX; m[5] = S_MIN; m[6] = S_MIN; m[7] = S_MAX;
		add_row(m);
		m[1] = S_MAX; m[3] = S_MIN; m[5] = S_MAX; m[7] = S_MIN;
		add_row(m);
		// 90 degrees about z
		m = fill(0);
		m[1] = -P_ONE; m[3] = P_ONE; m[8] = P_ONE;
		add_row(m);
		m = fill(0);
		m[2] = P_ONE; m[6] = -P_ONE; m[4] = P_ONE;
		add_row(m);
		m = fill(0);
		m[5] = -P_ONE; m[7] = P_ONE; m[0] = P_ONE;
		add_row(m);
		m = fill(0);
		m[1] = S_MAX; m[3] = S_MAX; m[0] = -P_ONE; m[4] = -P_ONE;
		add_row(m);
	endtask

	task automatic send_matrix(vector_t v);
		logic [167:0] word;
		quat_t q;
		word = '0;
		foreach (v.m[i]) word[i*18 +: 18] = v.m[i];
		q = v.known ? v.q : matrix_to_quat(v.m);
		repeat ($urandom_range(0, 3)) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= word;
		quat_queue.push_back(q);
		do @(posedge clk); while (!s_tready);
	endtask

	// receiver: random stalls, one long hold-off while the sender keeps going
	initial begin
		int wait_cycles;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				m_tready <= 1'b0;
				repeat (200) @(posedge clk);
				hold_off = 0;
			end
			wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
			if (wait_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// result checker
	always @(posedge clk) begin
		quat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (quat_queue.size() == 0) begin
				$display("unexpected transaction at %0t", $time);
				errors++;
			end else begin
				want = quat_queue.pop_front();
				if (q16_t'(m_tdata[17:0]) !== want.x)
					report_mismatch("quat_x", q16_t'(m_tdata[17:0]), want.x);
				if (q16_t'(m_tdata[35:18]) !== want.y)
					report_mismatch("quat_y", q16_t'(m_tdata[35:18]), want.y);
				if (q16_t'(m_tdata[53:36]) !== want.z)
					report_mismatch("quat_z", q16_t'(m_tdata[53:36]), want.z);
				if (q16_t'(m_tdata[71:54]) !== want.w)
					report_mismatch("quat_w", q16_t'(m_tdata[71:54]), want.w);
				if (m_tuser !== want.ok)
					report_mismatch("valid_res", m_tuser, want.ok);
			end
		end
	end

	initial begin
		vector_t v;
		int r;
		errors = 0;
		hold_off = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		build_directed();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (vectors[i]) send_matrix(vectors[i]);
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == 100) hold_off = 1;
			r = $urandom_range(0, 9);
			v.known = 0;
			if (r < 6) begin
				v.m = random_matrix(1);
			end else if (r < 8) begin
				v.m = random_matrix(0);
			end else begin
				// near the threshold of the trace candidate
				v.m = random_matrix(1);
				v.m[0] = q16_t'($urandom_range(0, 8192) - 25000);
				v.m[4] = q16_t'($urandom_range(0, 8192) - 25000);
				v.m[8] = q16_t'($urandom_range(0, 8192) - 25000);
			end
			send_matrix(v);
		end
		s_tvalid <= 1'b0;
		r = 0;
		while (quat_queue.size() != 0 && r < 100000) begin
			@(posedge clk);
			r++;
		end
		repeat (100) @(posedge clk);
		if (errors == 0 && quat_queue.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
